FILE: src/allpass_delay_filter_assert.svh
// assertion macros shared by the allpass delay filter sources
`ifndef ALLPASS_DELAY_FILTER_ASSERT_SVH
`define ALLPASS_DELAY_FILTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ADF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ADF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/adf_pkg.sv
// ---------------------------------------------------------------------------
// adf_pkg
// Shared types and constants of the allpass delay filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package adf_pkg;

    // register map
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DELAY = 2'd1;

    // field widths
    localparam int GAIN_BITS  = 16;
    localparam int DELAY_BITS = 13;
    localparam int COEF_BITS  = 17;
    localparam int CG_BITS    = 32;
    localparam int GSQ_BITS   = 32;

    // gain after reset: 0.5 in Q1.15
    localparam logic signed [GAIN_BITS-1:0] GAIN_RESET = 16'sd16384;

    // derived coefficients handed from the coefficient unit to the datapath
    typedef struct packed {
        logic                          busy;
        logic signed [GAIN_BITS-1:0]   gain;
        logic signed [COEF_BITS-1:0]   c;
        logic signed [CG_BITS-1:0]     cg;
    } t_coef;

endpackage

`default_nettype wire

FILE: src/adf_ram.sv
// ---------------------------------------------------------------------------
// adf_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module adf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/adf_coef.sv
// ---------------------------------------------------------------------------
// adf_coef
// Gain register (Q1.15) and derived coefficients c = 1 - g^2 (Q2.15) and c*g (Q2.30).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "allpass_delay_filter_assert.svh"

module adf_coef
    import adf_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_gain_we,
    input  wire logic signed [GAIN_BITS-1:0] i_gain_data,
    output t_coef                            o_coef
);

    logic signed [GAIN_BITS-1:0] r_gain;
    logic [2:0]                  r_step;
    logic signed [GSQ_BITS-1:0]  r_gsq_prod;
    logic signed [COEF_BITS-1:0] r_c;
    logic signed [CG_BITS-1:0]   r_cg;
    logic signed [GSQ_BITS-1:0]  n_gsq;

    // gain register and refresh sequence: square, subtract, multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_step <= 3'b001;
        end else if (i_gain_we) begin
            r_gain <= i_gain_data;
            r_step <= 3'b001;
        end else begin
            r_step <= {r_step[1:0], 1'b0};
        end
    end

    // rounded g^2 in Q1.15
    assign n_gsq = (r_gsq_prod + 32'sd16384) >>> 15;

    // coefficient datapath
    always_ff @(posedge i_clk) begin
        if (r_step[0]) begin
            r_gsq_prod <= GSQ_BITS'(r_gain * r_gain);
        end
        if (r_step[1]) begin
            r_c <= COEF_BITS'(32'sd32768 - n_gsq);
        end
        if (r_step[2]) begin
            r_cg <= CG_BITS'(r_c * r_gain);
        end
    end

    assign o_coef.busy = |r_step;
    assign o_coef.gain = r_gain;
    assign o_coef.c    = r_c;
    assign o_coef.cg   = r_cg;

    // one refresh step at a time
    `ADF_ASSERT_IMP(a_step_onehot, i_clk, i_rst_n, 1'b1, $onehot0(r_step), "refresh steps overlap")

endmodule

`default_nettype wire

FILE: src/allpass_delay_filter.sv
// ---------------------------------------------------------------------------
// allpass_delay_filter
// Schroeder allpass with a delay of D samples, 24-bit audio, Q1.15 gain.
// ---------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  input    | i_in_valid o_in_ready i_sample_in        | in
//  output   | o_out_valid i_out_ready o_sample_out     | out
//  config   | i_cfg_valid o_cfg_ready i_cfg_index/data | in
//
// A sample goes through a history read, three parallel multiplies, the wide
// sum, then saturation with write-back to the history RAM and the output register.
// After reset or a gain write the coefficient unit refreshes c and c*g, input not ready.
// Config waits for an idle sequencer and holds off the input while offered.
// A delay write or reset empties the histories through a wrap flag, no clearing pass.
// A full output register holds the write-back step until the result is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "allpass_delay_filter_assert.svh"

module allpass_delay_filter
    import adf_pkg::*;
#(
    parameter int MAX_DELAY   = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int PW   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int DW   = $clog2(MAX_DELAY + 1);
    localparam int CMPW = (DW > DELAY_BITS) ? DW : DELAY_BITS;
    localparam int AW   = SB + 35;
    localparam int YW   = AW - 30;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_WR   = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [PW-1:0]           r_pos;
    logic [DW-1:0]           r_delay;
    logic                    r_wrapped;
    logic                    r_out_valid;
    logic signed [SB-1:0]    r_sample_out;
    logic signed [SB-1:0]    r_x;
    logic signed [SB+16:0]   r_p1;
    logic signed [SB+15:0]   r_p2;
    logic signed [SB+31:0]   r_p3;
    logic signed [AW-1:0]    r_acc;

    t_coef                   coef;
    logic                    in_xfer;
    logic                    cfg_xfer;
    logic                    gain_we;
    logic                    delay_we;
    logic                    advance;
    logic                    pos_wrap;
    logic [CMPW-1:0]         delay_req;
    logic [DW-1:0]           delay_new;
    logic [2*SB-1:0]         ram_rdata;
    logic signed [SB-1:0]    xo;
    logic signed [SB-1:0]    yo;
    logic signed [AW-1:0]    n_acc;
    logic signed [YW-1:0]    y_full;
    logic signed [SB-1:0]    y_sat;

    // handshakes: config only between samples and ahead of a new sample
    assign o_in_ready  = (r_state == ST_IDLE) && !coef.busy && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign gain_we     = cfg_xfer && (i_cfg_index == REG_GAIN);
    assign delay_we    = cfg_xfer && (i_cfg_index == REG_DELAY);
    assign advance     = (r_state == ST_WR) && (!r_out_valid || i_out_ready);

    // gain and derived coefficients
    adf_coef u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain_we   (gain_we),
        .i_gain_data (i_cfg_data[GAIN_BITS-1:0]),
        .o_coef      (coef)
    );

    // delay clamp to 1..MAX_DELAY
    always_comb begin
        delay_req = CMPW'(i_cfg_data[DELAY_BITS-1:0]);
        if (delay_req == '0) begin
            delay_req = CMPW'(1);
        end else if (delay_req > CMPW'(MAX_DELAY)) begin
            delay_req = CMPW'(MAX_DELAY);
        end
        delay_new = DW'(delay_req);
    end

    // both histories side by side: input in the upper half, output below
    adf_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_DELAY)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (advance),
        .i_waddr (r_pos),
        .i_wdata ({r_x, y_sat}),
        .i_re    (in_xfer),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // entries not yet written since the last clear read as zero
    assign xo = r_wrapped ? ram_rdata[2*SB-1:SB] : '0;
    assign yo = r_wrapped ? ram_rdata[SB-1:0]    : '0;

    // ring position wraps at the delay
    assign pos_wrap = (DW'(r_pos) + DW'(1)) == r_delay;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_xfer) n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_WR;
            ST_WR:   if (advance) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_delay     <= DW'(1);
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (delay_we) begin
                r_delay   <= delay_new;
                r_pos     <= '0;
                r_wrapped <= 1'b0;
            end else if (advance) begin
                if (pos_wrap) begin
                    r_pos     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_pos <= r_pos + PW'(1);
                end
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // wide sum with round half up at scale 2^30
    always_comb begin
        n_acc = ((AW'(r_p1) - AW'(r_p2)) <<< 15) + AW'(r_p3) + (AW'(1) <<< 29);
    end

    // saturation to the sample width
    assign y_full = YW'(r_acc >>> 30);
    always_comb begin
        if ((&y_full[YW-1:SB-1]) || !(|y_full[YW-1:SB-1])) begin
            y_sat = y_full[SB-1:0];
        end else if (y_full[YW-1]) begin
            y_sat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SB-1){1'b1}}};
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x <= i_sample_in;
        end
        if (r_state == ST_MUL) begin
            r_p1 <= (SB+17)'(coef.c * xo);
            r_p2 <= (SB+16)'(coef.gain * r_x);
            r_p3 <= (SB+32)'(coef.cg * yo);
        end
        if (r_state == ST_SUM) begin
            r_acc <= n_acc;
        end
        if (advance) begin
            r_sample_out <= y_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

    // checks on sequencing and ring control
    `ADF_ASSERT_NXT(a_accept_mul, i_clk, i_rst_n, in_xfer, r_state == ST_MUL, "no multiply")
    `ADF_ASSERT_NXT(a_wr_out, i_clk, i_rst_n, advance, o_out_valid && (r_state == ST_IDLE), "no out")
    `ADF_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, DW'(r_pos) < r_delay, "ring pos range")
    `ADF_ASSERT_NXT(a_delay_clear, i_clk, i_rst_n, delay_we, (r_pos == '0) && !r_wrapped, "no clear")

endmodule

`default_nettype wire
